// ===== rtl/dual_encoder_period_tachometer_top_macros.svh =====
// Assertion macros shared by the tachometer RTL.
`ifndef DUAL_ENCODER_PERIOD_TACHOMETER_TOP_MACROS_SVH
`define DUAL_ENCODER_PERIOD_TACHOMETER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tachometer assertion failed");

// Next-cycle implication, disabled during reset.
`define DEPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tachometer assertion failed");

`endif

// ===== rtl/dept_pkg.sv =====
// Package with widths, constants, codes and types of the tachometer.
package dept_pkg;

  localparam int BLOCK_LEN  = 6;
  localparam int TIMER_BITS = 16;

  localparam int REQ_W = 2;
  localparam int CAP_W = 16;
  localparam int LIM_W = 20;
  localparam int RUN_W = 22;
  localparam int PER_W = 21;
  localparam int SUM_W = 23;
  localparam int TOT_W = 32;
  localparam int CNT_W = $clog2(BLOCK_LEN);

  localparam logic [LIM_W-1:0] STOP_LIMIT_RESET = LIM_W'(1000000);
  localparam logic [PER_W-1:0] PERIOD_MAX       = {PER_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_MASK         = CAP_W'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic signed [RUN_W:0] WRAP_INC    = $signed((RUN_W+1)'(64'd1 << TIMER_BITS));

  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int MUL_W     = DIV_SHIFT;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

  typedef enum logic [REQ_W-1:0] {
    REQ_WRAP        = 2'd0,
    REQ_RIGHT       = 2'd1,
    REQ_LEFT        = 2'd2,
    REQ_CLEAR_EDGES = 2'd3
  } req_e;

  typedef struct packed {
    logic signed [RUN_W-1:0] running;
    logic [PER_W-1:0]        last;
    logic [SUM_W-1:0]        sum;
    logic [CNT_W-1:0]        count;
    logic [TOT_W-1:0]        total;
  } chan_t;

  typedef struct packed {
    chan_t            ch;
    logic             go;
    logic [SUM_W-1:0] div_sum;
  } cap_res_t;

endpackage

// ===== rtl/dept_req_if.sv =====
// Event input channel of the tachometer.
interface dept_req_if import dept_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CAP_W-1:0] capture_value;

  modport source (output valid, req_type, capture_value, input ready);
  modport sink (input valid, req_type, capture_value, output ready);
endinterface

// ===== rtl/dept_res_if.sv =====
// Result output channel of the tachometer.
interface dept_res_if import dept_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PER_W-1:0] right_period;
  logic [PER_W-1:0] left_period;
  logic [PER_W-1:0] right_average;
  logic [PER_W-1:0] left_average;
  logic [TOT_W-1:0] right_edges;
  logic [TOT_W-1:0] left_edges;

  modport source (output valid, right_period, left_period, right_average, left_average,
                  right_edges, left_edges, input ready);
  modport sink (input valid, right_period, left_period, right_average, left_average,
                right_edges, left_edges, output ready);
endinterface

// ===== rtl/dept_cfg_if.sv =====
// Configuration write channel of the tachometer.
interface dept_cfg_if import dept_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] stop_limit;

  modport source (output valid, stop_limit, input ready);
  modport sink (input valid, stop_limit, output ready);
endinterface

// ===== rtl/dual_encoder_period_tachometer_top.sv =====
// Top level of the two-channel encoder period tachometer.
// Each accepted event beat is registered in stage one, then in the output result register.
// Throughput: one event per cycle unless back-pressure stalls; channel state updates on accept.
// The block average divide is a reciprocal multiply in the second stage.
// Reset clears all channel state and sets stop_limit to 1000000.
`include "dual_encoder_period_tachometer_top_macros.svh"

module dual_encoder_period_tachometer_top import dept_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dept_req_if.sink   req_i,
  dept_cfg_if.sink   cfg_i,
  dept_res_if.source res_o
);

  function automatic chan_t chan_wrap(chan_t c, logic [LIM_W-1:0] lim);
    logic signed [RUN_W:0] inc;
    logic signed [RUN_W:0] limx;
    chan_t w;
    inc  = {c.running[RUN_W-1], c.running} + WRAP_INC;
    limx = $signed({{(RUN_W+1-LIM_W){1'b0}}, lim});
    w = c;
    if (inc >= limx) begin
      w.running = $signed({{(RUN_W-LIM_W){1'b0}}, lim});
      w.last    = {{(PER_W-LIM_W){1'b0}}, lim};
    end else begin
      w.running = inc[RUN_W-1:0];
    end
    return w;
  endfunction

  function automatic cap_res_t chan_capture(chan_t c, logic [CAP_W-1:0] cap);
    logic signed [RUN_W:0] p;
    logic [PER_W-1:0]      per;
    logic [SUM_W-1:0]      sum_new;
    logic [CNT_W:0]        cnt_next;
    cap_res_t r;
    p        = {c.running[RUN_W-1], c.running} + $signed({{(RUN_W+1-CAP_W){1'b0}}, cap});
    per      = '0;
    if (p[RUN_W]) begin
      per = '0;
    end else if (p > $signed({2'b00, PERIOD_MAX})) begin
      per = PERIOD_MAX;
    end else begin
      per = p[PER_W-1:0];
    end
    sum_new  = c.sum + SUM_W'(per);
    cnt_next = {1'b0, c.count} + (CNT_W+1)'(1);
    r.ch         = c;
    r.ch.last    = per;
    r.ch.running = -$signed({{(RUN_W-CAP_W){1'b0}}, cap});
    r.ch.total   = c.total + TOT_W'(1);
    r.div_sum    = sum_new;
    if (cnt_next >= (CNT_W+1)'(BLOCK_LEN)) begin
      r.go       = 1'b1;
      r.ch.sum   = '0;
      r.ch.count = '0;
    end else begin
      r.go       = 1'b0;
      r.ch.sum   = sum_new;
      r.ch.count = cnt_next[CNT_W-1:0];
    end
    return r;
  endfunction

  logic [LIM_W-1:0] limit_q;
  chan_t            right_q, right_d;
  chan_t            left_q, left_d;
  logic             s1_valid_q;
  logic             s1_rgo_q, s1_rgo_d;
  logic             s1_lgo_q, s1_lgo_d;
  logic [SUM_W-1:0] s1_rsum_q, s1_rsum_d;
  logic [SUM_W-1:0] s1_lsum_q, s1_lsum_d;
  logic             out_valid_q;
  logic [PER_W-1:0] out_rper_q, out_lper_q;
  logic [PER_W-1:0] out_ravg_q, out_lavg_q;
  logic [TOT_W-1:0] out_redge_q, out_ledge_q;

  logic             out_free;
  logic             s1_adv;
  logic             in_acc;
  logic [CAP_W-1:0] cap_m;
  cap_res_t         rcap, lcap;
  logic [SUM_W+MUL_W-1:0] rprod, lprod;

  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;
  assign in_acc      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cap_m = req_i.capture_value & CAP_MASK;
  assign rcap  = chan_capture(right_q, cap_m);
  assign lcap  = chan_capture(left_q, cap_m);

  always_comb begin
    right_d   = right_q;
    left_d    = left_q;
    s1_rgo_d  = 1'b0;
    s1_lgo_d  = 1'b0;
    s1_rsum_d = rcap.div_sum;
    s1_lsum_d = lcap.div_sum;
    unique case (req_e'(req_i.req_type))
      REQ_WRAP: begin
        right_d = chan_wrap(right_q, limit_q);
        left_d  = chan_wrap(left_q, limit_q);
      end
      REQ_RIGHT: begin
        right_d  = rcap.ch;
        s1_rgo_d = rcap.go;
      end
      REQ_LEFT: begin
        left_d   = lcap.ch;
        s1_lgo_d = lcap.go;
      end
      REQ_CLEAR_EDGES: begin
        right_d.total = '0;
        left_d.total  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= STOP_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.stop_limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q    <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
      s1_rgo_q   <= 1'b0;
      s1_lgo_q   <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
      if (in_acc) begin
        right_q  <= right_d;
        left_q   <= left_d;
        s1_rgo_q <= s1_rgo_d;
        s1_lgo_q <= s1_lgo_d;
      end else begin
        s1_rgo_q <= 1'b0;
        s1_lgo_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rsum_q <= s1_rsum_d;
      s1_lsum_q <= s1_lsum_d;
    end
  end

  assign rprod = (SUM_W+MUL_W)'(s1_rsum_q) * (SUM_W+MUL_W)'(DIV_MUL);
  assign lprod = (SUM_W+MUL_W)'(s1_lsum_q) * (SUM_W+MUL_W)'(DIV_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ravg_q  <= '0;
      out_lavg_q  <= '0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
      if (s1_adv && s1_rgo_q) begin
        out_ravg_q <= rprod[DIV_SHIFT +: PER_W];
      end
      if (s1_adv && s1_lgo_q) begin
        out_lavg_q <= lprod[DIV_SHIFT +: PER_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_rper_q  <= right_q.last;
      out_lper_q  <= left_q.last;
      out_redge_q <= right_q.total;
      out_ledge_q <= left_q.total;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.right_period  = out_rper_q;
  assign res_o.left_period   = out_lper_q;
  assign res_o.right_average = out_ravg_q;
  assign res_o.left_average  = out_lavg_q;
  assign res_o.right_edges   = out_redge_q;
  assign res_o.left_edges    = out_ledge_q;

  `DEPT_ASSERT_NEXT(a_right_edge_inc, clk_i, rst_ni,
    in_acc && req_i.req_type == REQ_RIGHT, right_q.total == $past(right_q.total) + TOT_W'(1))
  `DEPT_ASSERT_NOW(a_block_count_range, clk_i, rst_ni,
    1'b1, right_q.count < CNT_W'(BLOCK_LEN) && left_q.count < CNT_W'(BLOCK_LEN))
  `DEPT_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, req_i.ready)
  `DEPT_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni, s1_adv, out_valid_q)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-channel encoder period tachometer.
module testbench;
  import dept_pkg::*;

  localparam int SIDE_RIGHT = 0;
  localparam int SIDE_LEFT = 1;
  localparam logic [LIM_W-1:0] LIMIT_MIN = LIM_W'(65536);
  localparam logic [LIM_W-1:0] LIMIT_MAX = {LIM_W{1'b1}};
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 260;

  typedef struct packed {
    logic [PER_W-1:0] right_period;
    logic [PER_W-1:0] left_period;
    logic [PER_W-1:0] right_average;
    logic [PER_W-1:0] left_average;
    logic [TOT_W-1:0] right_edges;
    logic [TOT_W-1:0] left_edges;
  } reading_t;

  typedef struct {
    longint           running;
    logic [PER_W-1:0] last;
    longint           block_sum;
    int               block_count;
    logic [PER_W-1:0] mean;
    logic [TOT_W-1:0] edges;
  } wheel_t;

  class tach_checker;
    logic [LIM_W-1:0] stop_limit;
    wheel_t           wheel[2];
    reading_t         expected_readings[$];
    int               errors;

    function new();
      stop_limit = STOP_LIMIT_RESET;
      errors = 0;
      foreach (wheel[s]) begin
        wheel[s].running = 0;
        wheel[s].last = '0;
        wheel[s].block_sum = 0;
        wheel[s].block_count = 0;
        wheel[s].mean = '0;
        wheel[s].edges = '0;
      end
    endfunction

    function void set_limit(logic [LIM_W-1:0] value);
      stop_limit = value;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void add_timer_period(int s);
      wheel[s].running += longint'(1) << TIMER_BITS;
      if (wheel[s].running >= longint'(stop_limit)) begin
        wheel[s].running = longint'(stop_limit);
        wheel[s].last = PER_W'(stop_limit);
      end
    endfunction

    function void take_capture(int s, logic [CAP_W-1:0] cap);
      longint period;
      period = wheel[s].running + longint'(cap);
      if (period < 0) period = 0;
      if (period > longint'(PERIOD_MAX)) period = longint'(PERIOD_MAX);
      wheel[s].last = PER_W'(period);
      wheel[s].running = -longint'(cap);
      wheel[s].edges = wheel[s].edges + 1'b1;
      wheel[s].block_sum += period;
      wheel[s].block_count++;
      if (wheel[s].block_count >= BLOCK_LEN) begin
        wheel[s].mean = PER_W'(wheel[s].block_sum / BLOCK_LEN);
        wheel[s].block_sum = 0;
        wheel[s].block_count = 0;
      end
    endfunction

    function void note_event(req_e kind, logic [CAP_W-1:0] value);
      logic [CAP_W-1:0] cap;
      reading_t         r;
      cap = value & CAP_MASK;
      case (kind)
        REQ_WRAP: begin
          add_timer_period(SIDE_RIGHT);
          add_timer_period(SIDE_LEFT);
        end
        REQ_RIGHT: take_capture(SIDE_RIGHT, cap);
        REQ_LEFT: take_capture(SIDE_LEFT, cap);
        REQ_CLEAR_EDGES: begin
          wheel[SIDE_RIGHT].edges = '0;
          wheel[SIDE_LEFT].edges = '0;
        end
      endcase
      r.right_period = wheel[SIDE_RIGHT].last;
      r.left_period = wheel[SIDE_LEFT].last;
      r.right_average = wheel[SIDE_RIGHT].mean;
      r.left_average = wheel[SIDE_LEFT].mean;
      r.right_edges = wheel[SIDE_RIGHT].edges;
      r.left_edges = wheel[SIDE_LEFT].edges;
      expected_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [TOT_W-1:0] want, logic [TOT_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        return;
      end
      want = expected_readings.pop_front();
      compare_field("right_period", TOT_W'(want.right_period), TOT_W'(got.right_period));
      compare_field("left_period", TOT_W'(want.left_period), TOT_W'(got.left_period));
      compare_field("right_average", TOT_W'(want.right_average), TOT_W'(got.right_average));
      compare_field("left_average", TOT_W'(want.left_average), TOT_W'(got.left_average));
      compare_field("right_edges", want.right_edges, got.right_edges);
      compare_field("left_edges", want.left_edges, got.left_edges);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   quiet_tail = 1'b0;
  int   events_accepted = 0;
  int   src_stretch = 0;
  int   src_level = 0;
  int   timer_now = 0;

  tach_checker sb;

  dept_req_if req_if ();
  dept_cfg_if cfg_if ();
  dept_res_if res_if ();

  dual_encoder_period_tachometer_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    reading_t seen;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_event(req_e'(req_if.req_type), req_if.capture_value);
        events_accepted++;
      end
      if (cfg_if.valid && cfg_if.ready) sb.set_limit(cfg_if.stop_limit);
      if (res_if.valid && res_if.ready) begin
        seen.right_period = res_if.right_period;
        seen.left_period = res_if.left_period;
        seen.right_average = res_if.right_average;
        seen.left_average = res_if.left_average;
        seen.right_edges = res_if.right_edges;
        seen.left_edges = res_if.left_edges;
        sb.check_result(seen);
      end
    end
  end

  // Result receiver with random stalls and one long hold-off to back up the pipeline.
  initial begin
    int   gap_left;
    int   stretch;
    int   level;
    int   hold_left;
    bit   held;
    logic nxt;
    gap_left = 0;
    stretch = 0;
    level = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(10, 80);
        level = $urandom_range(0, 3);
      end
      stretch--;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (!held && events_accepted >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        nxt = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        nxt = 1'b0;
      end else if (!quiet_tail && level != 0 && $urandom_range(0, 2 * level) == 0) begin
        gap_left = $urandom_range(1, 7) - 1;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      res_if.ready <= nxt;
    end
  end

  task automatic send_event(req_e kind, logic [CAP_W-1:0] value);
    int gap;
    if (src_stretch == 0) begin
      src_stretch = $urandom_range(10, 80);
      src_level = $urandom_range(0, 3);
    end
    src_stretch--;
    gap = 0;
    if (!quiet_tail && src_level != 0 && $urandom_range(0, 2 * src_level) == 0)
      gap = $urandom_range(1, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.capture_value <= value;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.stop_limit <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CAP_W-1:0] pick_capture();
    logic [CAP_W-1:0] cap;
    case ($urandom_range(0, 9))
      0: cap = '0;
      1: cap = {CAP_W{1'b1}};
      2, 3: cap = CAP_W'($urandom);
      default: cap = CAP_W'($urandom_range(timer_now, 65535));
    endcase
    timer_now = int'(cap);
    return cap;
  endfunction

  // Encoder-like traffic: most captures climb through each timer period, wraps restart it.
  task automatic run_traffic(int count);
    int sent;
    int r;
    int run;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        run = $urandom_range(5, 20);
        repeat (run) send_event(REQ_WRAP, CAP_W'($urandom));
        timer_now = 0;
        sent += run;
      end else begin
        if (r < 28) begin
          send_event(REQ_WRAP, CAP_W'($urandom));
          timer_now = 0;
        end else if (r < 62) begin
          send_event(REQ_RIGHT, pick_capture());
        end else if (r < 94) begin
          send_event(REQ_LEFT, pick_capture());
        end else begin
          send_event(REQ_CLEAR_EDGES, CAP_W'($urandom));
        end
        sent++;
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    req_if.valid = 1'b0;
    req_if.req_type = REQ_WRAP;
    req_if.capture_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.stop_limit = '0;
    res_if.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_event(REQ_RIGHT, 16'hFFFF);
    send_event(REQ_RIGHT, 16'h0064);
    send_event(REQ_LEFT, 16'h0000);
    send_event(REQ_LEFT, 16'hFFFF);
    send_event(REQ_WRAP, 16'hFFFF);
    send_event(REQ_RIGHT, 16'h5555);
    send_event(REQ_RIGHT, 16'hAAAA);
    send_event(REQ_RIGHT, 16'h0000);
    send_event(REQ_RIGHT, 16'hFFFF);
    send_event(REQ_CLEAR_EDGES, 16'hA5A5);
    send_event(REQ_LEFT, 16'h8000);
    send_event(REQ_WRAP, 16'h0000);
    send_event(REQ_WRAP, 16'h5A5A);
    send_event(REQ_LEFT, 16'h0001);
    send_event(REQ_LEFT, 16'h7FFF);
    send_event(REQ_LEFT, 16'h0000);
    send_event(REQ_CLEAR_EDGES, 16'h0000);

    write_limit(LIMIT_MIN);
    send_event(REQ_WRAP, 16'h0000);
    send_event(REQ_WRAP, 16'hFFFF);
    send_event(REQ_RIGHT, 16'hFFFF);
    send_event(REQ_LEFT, 16'h0000);

    write_limit(LIMIT_MAX);
    run_traffic(PHASE_ITEMS);
    repeat (14) send_event(REQ_WRAP, CAP_W'($urandom));

    // The lowered limit leaves both running counts above it until each side's next capture.
    write_limit(LIMIT_MIN);
    send_event(REQ_LEFT, 16'h1234);
    send_event(REQ_RIGHT, 16'h0042);
    send_event(REQ_WRAP, 16'h0000);
    timer_now = 0;
    run_traffic(PHASE_ITEMS);

    write_limit(LIM_W'($urandom_range(65536, 1048575)));
    run_traffic(PHASE_ITEMS);
    write_limit(STOP_LIMIT_RESET);
    run_traffic(PHASE_ITEMS);
    write_limit(LIM_W'($urandom_range(65536, 200000)));
    run_traffic(PHASE_ITEMS);

    @(posedge clk_i);
    quiet_tail = 1'b1;
    write_limit(LIMIT_MAX);
    run_traffic(PHASE_ITEMS);

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dept_pkg.sv
rtl/dept_req_if.sv
rtl/dept_res_if.sv
rtl/dept_cfg_if.sv
rtl/dual_encoder_period_tachometer_top.sv
tb/testbench.sv
